FILE: rtl/core/fqs_pkg.sv
// Package for the FIFO queue with search: widths, request codes and status codes.
// No dependencies; the interfaces and the top level use it by scoped names.

package fqs_pkg;

	// Default queue depth and fixed field widths
	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int REQ_W     = 2;
	localparam int STAT_W    = 2;

	// Request codes
	localparam logic [REQ_W-1:0] REQ_ENQ  = 2'd0;
	localparam logic [REQ_W-1:0] REQ_DEQ  = 2'd1;
	localparam logic [REQ_W-1:0] REQ_SRCH = 2'd2;

	// Result status codes
	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd1;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

endpackage

FILE: rtl/core/fqs_req_if.sv
// Request channel of the FIFO queue with search: valid/ready plus request payload.
// Depends on fqs_pkg for field widths.

interface fqs_req_if;

	logic                               valid;
	logic                               ready;
	logic [fqs_pkg::REQ_W-1:0]          req_type;
	logic signed [fqs_pkg::DATA_W-1:0]  push_value;
	logic signed [fqs_pkg::DATA_W-1:0]  search_key;

	modport source (output valid, output req_type, output push_value, output search_key,
		input ready);
	modport sink (input valid, input req_type, input push_value, input search_key,
		output ready);

endinterface

FILE: rtl/core/fqs_rsp_if.sv
// Result channel of the FIFO queue with search: valid/ready plus result payload.
// Depends on fqs_pkg; CNT_W sizes the position and fill level fields.

interface fqs_rsp_if #(
	parameter int CNT_W = $clog2(fqs_pkg::DEPTH_DEF + 1)
);

	logic                               valid;
	logic                               ready;
	logic [fqs_pkg::STAT_W-1:0]         status;
	logic signed [fqs_pkg::DATA_W-1:0]  popped_value;
	logic [CNT_W-1:0]                   found_position;
	logic [CNT_W-1:0]                   fill_level;

	modport source (output valid, output status, output popped_value,
		output found_position, output fill_level, input ready);
	modport sink (input valid, input status, input popped_value,
		input found_position, input fill_level, output ready);

endinterface

FILE: rtl/core/fifo_queue_with_search.sv
// Top level of the FIFO queue with search: ring buffer in one RAM plus a sequencer.
// Depends on fqs_pkg, fqs_req_if, fqs_rsp_if and fqs_ram.

// A first-in first-out queue of DEPTH signed 32-bit values kept as a ring in a
// single-port-read RAM. Every request beat (enqueue, dequeue, search) returns
// exactly one result beat. One request is worked on at a time; a new request is
// taken as soon as the previous one has moved its result into the output
// register, even if that result has not been taken yet. Enqueue, the unused
// request code, and any request that meets a full or empty queue go from accept
// straight to ST_DONE; dequeue passes through ST_DEQ; a search compares held
// entries from the head in ST_SCAN, one stored entry per cycle from the one RAM
// read port, up to a match or the last one (none on an empty queue, else 1 to
// DEPTH). Overflow and underflow are reported in status and leave the queue
// unchanged. The RAM is not cleared; only held entries reach a result.

module fifo_queue_with_search #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  logic      clk,
	input  logic      arst_n,
	fqs_req_if.sink   req,
	fqs_rsp_if.source rsp
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEQ,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t                            state_q;
	logic [AW-1:0]                     head_q;
	logic [AW-1:0]                     tail_q;
	logic [CW-1:0]                     count_q;
	logic [AW-1:0]                     scan_idx_q;
	logic [CW-1:0]                     scan_n_q;
	logic [fqs_pkg::DATA_W-1:0]        key_q;
	logic [fqs_pkg::STAT_W-1:0]        res_status_q;
	logic signed [fqs_pkg::DATA_W-1:0] res_popped_q;
	logic [CW-1:0]                     res_pos_q;
	logic                              out_valid_q;
	logic [fqs_pkg::STAT_W-1:0]        out_status_q;
	logic signed [fqs_pkg::DATA_W-1:0] out_popped_q;
	logic [CW-1:0]                     out_pos_q;
	logic [CW-1:0]                     out_fill_q;

	logic                       ram_we;
	logic                       ram_re;
	logic [AW-1:0]              ram_raddr;
	logic [fqs_pkg::DATA_W-1:0] ram_rdata;
	logic                       req_fire;
	logic                       is_full;
	logic                       is_empty;
	logic [CW-1:0]              scan_n_inc;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
		ring_next = (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
	endfunction

	assign req.ready  = (state_q == ST_IDLE);
	assign req_fire   = req.valid && req.ready;
	assign is_full    = (count_q == CW'(DEPTH));
	assign is_empty   = (count_q == '0);
	assign scan_n_inc = scan_n_q + CW'(1);

	// RAM control: write on accepted enqueue to a non-full queue, read head or next scan entry
	assign ram_we    = req_fire && (req.req_type == fqs_pkg::REQ_ENQ) && !is_full;
	assign ram_re    = (state_q == ST_IDLE) || (state_q == ST_SCAN);
	assign ram_raddr = (state_q == ST_SCAN) ? scan_idx_q : head_q;

	fqs_ram #(
		.WIDTH (fqs_pkg::DATA_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_q),
		.wdata (req.push_value),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Sequencer, queue pointers and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			count_q      <= '0;
			scan_idx_q   <= '0;
			scan_n_q     <= '0;
			key_q        <= '0;
			res_status_q <= fqs_pkg::STAT_OK;
			res_popped_q <= '0;
			res_pos_q    <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= fqs_pkg::STAT_OK;
			out_popped_q <= '0;
			out_pos_q    <= '0;
			out_fill_q   <= '0;
		end else begin
			if (out_valid_q && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						res_status_q <= fqs_pkg::STAT_OK;
						res_popped_q <= '0;
						res_pos_q    <= '0;
						state_q      <= ST_DONE;
						case (req.req_type)
							fqs_pkg::REQ_ENQ: begin
								if (is_full) begin
									res_status_q <= fqs_pkg::STAT_FULL;
								end else begin
									tail_q  <= ring_next(tail_q);
									count_q <= count_q + CW'(1);
								end
							end
							fqs_pkg::REQ_DEQ: begin
								if (is_empty) begin
									res_status_q <= fqs_pkg::STAT_EMPTY;
								end else begin
									state_q <= ST_DEQ;
								end
							end
							fqs_pkg::REQ_SRCH: begin
								key_q <= req.search_key;
								if (is_empty) begin
									res_status_q <= fqs_pkg::STAT_NOTFOUND;
								end else begin
									scan_idx_q <= ring_next(head_q);
									scan_n_q   <= '0;
									state_q    <= ST_SCAN;
								end
							end
							default: begin
								// unused code: no operation
							end
						endcase
					end
				end
				ST_DEQ: begin
					// head entry read during accept cycle
					res_popped_q <= $signed(ram_rdata);
					head_q       <= ring_next(head_q);
					count_q      <= count_q - CW'(1);
					state_q      <= ST_DONE;
				end
				ST_SCAN: begin
					// ram_rdata holds the entry at position scan_n_q
					if (ram_rdata == key_q) begin
						res_pos_q <= scan_n_inc;
						state_q   <= ST_DONE;
					end else if (scan_n_inc == count_q) begin
						res_status_q <= fqs_pkg::STAT_NOTFOUND;
						state_q      <= ST_DONE;
					end else begin
						scan_n_q   <= scan_n_inc;
						scan_idx_q <= ring_next(scan_idx_q);
					end
				end
				ST_DONE: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_popped_q <= res_popped_q;
						out_pos_q    <= res_pos_q;
						out_fill_q   <= count_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.popped_value   = out_popped_q;
	assign rsp.found_position = out_pos_q;
	assign rsp.fill_level     = out_fill_q;

endmodule

FILE: rtl/core/fqs_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.

module fqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
